### hw/rtl/separator_stream_rmse_core_defines.svh
// Assertion macros shared by the separator stream RMSE core.
`ifndef SEPARATOR_STREAM_RMSE_CORE_DEFINES_SVH
`define SEPARATOR_STREAM_RMSE_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Checked at every clock edge outside reset.
`define SEPR_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error("separator stream rmse assertion failed");
// Checked at every clock edge, reset included.
`define SEPR_ASSERT_ALWAYS(lbl, prop) \
   lbl: assert property (@(posedge clock) (prop)) \
      else $error("separator stream rmse assertion failed");
`else
`define SEPR_ASSERT(lbl, prop)
`define SEPR_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

### hw/rtl/sepr_pkg.sv
// Package with the constants and types of the separator stream RMSE core.
package sepr_pkg;

   localparam int COUNT_BITS = 27;
   localparam int RATED_BITS = 27;
   localparam int WORD_BITS  = 32;
   localparam int PRED_BITS  = 16;
   localparam int RATE_BITS  = 3;
   localparam int SQ_BITS    = 32;
   localparam int SUM_BITS   = 64;
   localparam int MEAN_BITS  = 32;
   localparam int ROOT_BITS  = 16;
   localparam int STEP_BITS  = $clog2(SUM_BITS);
   // The shared subtractor covers the divide remainder and the root remainder.
   localparam int SUB_BITS   = (COUNT_BITS + 1 > 20) ? COUNT_BITS + 1 : 20;

   localparam logic [PRED_BITS-1:0]  STAR_SCALE  = PRED_BITS'(10000);
   localparam logic [RATE_BITS-1:0]  TOP_RATING  = RATE_BITS'(5);
   localparam logic [RATE_BITS-1:0]  LOW_RATING  = RATE_BITS'(1);
   localparam logic [COUNT_BITS-1:0] COUNT_LIMIT = {COUNT_BITS{1'b1}};

   typedef struct packed {
      logic start;
      logic ack;
   } sepr_ctl_type;

   typedef struct packed {
      logic done;
   } sepr_sts_type;

endpackage

### hw/rtl/sepr_divsqrt.sv
// Iterative divide then integer square root on one shared subtractor.
`include "separator_stream_rmse_core_defines.svh"

module sepr_divsqrt (
   input  logic                              clock,
   input  logic                              reset,
   input  sepr_pkg::sepr_ctl_type            ctl,
   input  logic [sepr_pkg::SUM_BITS-1:0]     dividend,
   input  logic [sepr_pkg::COUNT_BITS-1:0]   divisor,
   output sepr_pkg::sepr_sts_type            sts,
   output logic [sepr_pkg::ROOT_BITS-1:0]    root
);
   import sepr_pkg::*;

   localparam logic [1:0] PH_IDLE = 2'd0;
   localparam logic [1:0] PH_DIV  = 2'd1;
   localparam logic [1:0] PH_SQRT = 2'd2;
   localparam logic [1:0] PH_DONE = 2'd3;

   logic [1:0]           phase_ff, phase_in;
   logic [STEP_BITS-1:0] step_ff, step_in;
   logic [SUM_BITS-1:0]  val_ff, val_in;
   logic [SUB_BITS-1:0]  rem_ff, rem_in;
   logic [ROOT_BITS-1:0] root_ff, root_in;

   logic [SUB_BITS-1:0]  div_a, sq_a, trial, op_a, op_b;
   logic [SUB_BITS:0]    diff;
   logic                 fits;

   // Divide brings in one dividend bit per step; the root brings in two mean bits.
   assign div_a = {rem_ff[SUB_BITS-2:0], val_ff[SUM_BITS-1]};
   assign sq_a  = {rem_ff[SUB_BITS-3:0], val_ff[MEAN_BITS-1 -: 2]};
   assign trial = SUB_BITS'({root_ff, 2'b01});
   assign op_a  = (phase_ff == PH_SQRT) ? sq_a : div_a;
   assign op_b  = (phase_ff == PH_SQRT) ? trial : SUB_BITS'(divisor);
   assign diff  = {1'b0, op_a} - {1'b0, op_b};
   assign fits  = !diff[SUB_BITS];

   always_comb begin
      phase_in = phase_ff;
      step_in  = step_ff;
      val_in   = val_ff;
      rem_in   = rem_ff;
      root_in  = root_ff;
      case (phase_ff)
         PH_IDLE: begin
            if (ctl.start) begin
               val_in   = dividend;
               rem_in   = '0;
               root_in  = '0;
               step_in  = '0;
               phase_in = PH_DIV;
            end
         end
         PH_DIV: begin
            rem_in  = fits ? diff[SUB_BITS-1:0] : op_a;
            val_in  = {val_ff[SUM_BITS-2:0], fits};
            step_in = step_ff + STEP_BITS'(1);
            if (step_ff == STEP_BITS'(SUM_BITS - 1)) begin
               // The quotient is complete; the root starts from a clean remainder.
               rem_in   = '0;
               step_in  = '0;
               phase_in = PH_SQRT;
            end
         end
         PH_SQRT: begin
            rem_in  = fits ? diff[SUB_BITS-1:0] : op_a;
            root_in = {root_ff[ROOT_BITS-2:0], fits};
            val_in  = {val_ff[SUM_BITS-3:0], 2'b00};
            step_in = step_ff + STEP_BITS'(1);
            if (step_ff == STEP_BITS'(ROOT_BITS - 1)) begin
               phase_in = PH_DONE;
            end
         end
         PH_DONE: begin
            if (ctl.ack) begin
               phase_in = PH_IDLE;
            end
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         step_ff  <= '0;
      end else begin
         phase_ff <= phase_in;
         step_ff  <= step_in;
      end
      val_ff  <= val_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign sts.done = (phase_ff == PH_DONE);
   assign root     = root_ff;

   `SEPR_ASSERT(a_start_when_idle, ctl.start |-> phase_ff == PH_IDLE)
   `SEPR_ASSERT(a_ack_when_done, ctl.ack |-> phase_ff == PH_DONE)
   `SEPR_ASSERT(a_done_holds, (sts.done && !ctl.ack) |=> sts.done)

endmodule

### hw/rtl/separator_stream_rmse_core.sv
// Top level of the separator stream RMSE core: accumulation, sequencing, result register.
//
// Requests arrive on req_valid/req_ready with a rating word, a prediction in
// units of 1/10000 star and a last flag. A zero word is a separator and steps
// the implied rating 1..5, wrapping back to 1. Any other word is scored: the
// squared difference of rating*10000 and the prediction is summed and counted,
// and the count saturates at its all-ones value.
// Requests that are not marked last are taken one per clock cycle.
// A request marked last produces one result on rsp_valid/rsp_ready: the floor
// square root of the floored mean squared error, the count and a flag set
// when nothing was scored. The mean and root come from one shared subtractor
// that runs 64 divide steps and then 16 root steps. req_ready is low from the
// time the last request is taken until the result is in the output register.
// The result sits in an output register; a stalled receiver holds it there
// while new requests are taken, and a second result waits in the sequencer.
// Reset (synchronous, active high) sets the rating to 1 and clears sum and
// count; the same happens after every result.
`include "separator_stream_rmse_core_defines.svh"

module separator_stream_rmse_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [sepr_pkg::WORD_BITS-1:0]     req_rating_word,
   input  logic [sepr_pkg::PRED_BITS-1:0]     req_prediction,
   input  logic                               req_last_item,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [sepr_pkg::ROOT_BITS-1:0]     rsp_rmse_scaled,
   output logic [sepr_pkg::RATED_BITS-1:0]    rsp_rated_count,
   output logic                               rsp_no_ratings
);
   import sepr_pkg::*;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_ADD   = 3'd1;
   localparam logic [2:0] ST_START = 3'd2;
   localparam logic [2:0] ST_CALC  = 3'd3;
   localparam logic [2:0] ST_EMPTY = 3'd4;

   logic [2:0]            state_ff, state_in;
   logic [RATE_BITS-1:0]  rating_ff, rating_in;
   logic [SUM_BITS-1:0]   sum_ff, sum_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic [SQ_BITS-1:0]    sq_ff, sq_in;
   logic                  sq_vld_ff, sq_vld_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [ROOT_BITS-1:0]  rmse_ff, rmse_in;
   logic [RATED_BITS-1:0] rated_ff, rated_in;
   logic                  none_ff, none_in;

   logic                  req_fire, rsp_free, finish;
   logic [PRED_BITS-1:0]  target, mag;
   logic [31:0]           count_wide;
   sepr_ctl_type          ctl;
   sepr_sts_type          sts;
   logic [ROOT_BITS-1:0]  root;

   sepr_divsqrt u_divsqrt (
      .clock    (clock),
      .reset    (reset),
      .ctl      (ctl),
      .dividend (sum_ff),
      .divisor  (count_ff),
      .sts      (sts),
      .root     (root)
   );

   assign req_ready  = (state_ff == ST_IDLE);
   assign req_fire   = req_valid && req_ready;
   assign rsp_free   = !rsp_valid_ff || rsp_ready;
   assign target     = PRED_BITS'(rating_ff) * STAR_SCALE;
   assign mag        = (target >= req_prediction) ? target - req_prediction
                                                  : req_prediction - target;
   assign count_wide = 32'(count_ff);

   always_comb begin
      state_in     = state_ff;
      rating_in    = rating_ff;
      count_in     = count_ff;
      sum_in       = sum_ff;
      sq_in        = sq_ff;
      sq_vld_in    = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rmse_in      = rmse_ff;
      rated_in     = rated_ff;
      none_in      = none_ff;
      ctl.start    = 1'b0;
      ctl.ack      = 1'b0;
      finish       = 1'b0;

      // The square of the previous request is held in sq_ff and added to the sum here.
      if (sq_vld_ff) begin
         sum_in = sum_ff + SUM_BITS'(sq_ff);
      end

      if (req_fire) begin
         if (req_rating_word == '0) begin
            rating_in = (rating_ff >= TOP_RATING) ? LOW_RATING : rating_ff + RATE_BITS'(1);
         end else if (count_ff != COUNT_LIMIT) begin
            count_in  = count_ff + COUNT_BITS'(1);
            sq_in     = SQ_BITS'(mag) * SQ_BITS'(mag);
            sq_vld_in = 1'b1;
         end
         if (req_last_item) begin
            state_in = ST_ADD;
         end
      end

      case (state_ff)
         ST_IDLE: begin
         end
         ST_ADD: begin
            state_in = ST_START;
         end
         ST_START: begin
            if (count_ff == '0) begin
               state_in = ST_EMPTY;
            end else begin
               ctl.start = 1'b1;
               state_in  = ST_CALC;
            end
         end
         ST_CALC: begin
            if (sts.done && rsp_free) begin
               ctl.ack      = 1'b1;
               rmse_in      = root;
               rated_in     = count_wide[RATED_BITS-1:0];
               none_in      = 1'b0;
               rsp_valid_in = 1'b1;
               finish       = 1'b1;
            end
         end
         ST_EMPTY: begin
            if (rsp_free) begin
               rmse_in      = '0;
               rated_in     = '0;
               none_in      = 1'b1;
               rsp_valid_in = 1'b1;
               finish       = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (finish) begin
         state_in  = ST_IDLE;
         rating_in = LOW_RATING;
         sum_in    = '0;
         count_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rating_ff    <= LOW_RATING;
         sum_ff       <= '0;
         count_ff     <= '0;
         sq_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rating_ff    <= rating_in;
         sum_ff       <= sum_in;
         count_ff     <= count_in;
         sq_vld_ff    <= sq_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      sq_ff    <= sq_in;
      rmse_ff  <= rmse_in;
      rated_ff <= rated_in;
      none_ff  <= none_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_rmse_scaled = rmse_ff;
   assign rsp_rated_count = rated_ff;
   assign rsp_no_ratings  = none_ff;

   `SEPR_ASSERT(a_last_blocks_input, (req_fire && req_last_item) |=> !req_ready)
   `SEPR_ASSERT(a_square_is_counted, sq_vld_ff |-> count_ff != '0)
   `SEPR_ASSERT(a_empty_result_zero,
      (rsp_valid && rsp_no_ratings) |-> (rsp_rmse_scaled == '0 && rsp_rated_count == '0))
   `SEPR_ASSERT_ALWAYS(a_no_square_after_reset, $past(reset) |-> !sq_vld_ff)

endmodule

### tb/sv/tb_separator_stream_rmse_core.sv
// Self-checking testbench for the separator stream RMSE core.
`timescale 1ns / 100ps

module tb_separator_stream_rmse_core;
   import sepr_pkg::*;

   typedef struct {
      logic [WORD_BITS-1:0] rating_word;
      logic [PRED_BITS-1:0] prediction;
      logic                 last_item;
   } request_type;

   typedef struct {
      logic [ROOT_BITS-1:0]  rmse_scaled;
      logic [RATED_BITS-1:0] rated_count;
      logic                  no_ratings;
   } score_type;

   typedef enum logic [1:0] {
      IDLE_NONE,
      IDLE_SENDER,
      IDLE_RECEIVER,
      IDLE_BOTH
   } idle_mode_type;

   localparam int RANDOM_REQUESTS = 2000;
   localparam int PHASE_REQUESTS  = 400;
   localparam int DRAIN_CYCLES    = 100;
   localparam int DRAIN_GUARD     = 100000;

   logic                  clock;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [WORD_BITS-1:0]  req_rating_word = '0;
   logic [PRED_BITS-1:0]  req_prediction = '0;
   logic                  req_last_item = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [ROOT_BITS-1:0]  rsp_rmse_scaled;
   logic [RATED_BITS-1:0] rsp_rated_count;
   logic                  rsp_no_ratings;

   request_type pending_requests[$];
   score_type   expected_scores[$];
   request_type next_request;
   score_type   observed_score;
   int          accepted_requests = 0;
   int          error_count = 0;

   // Shadow copy of the accumulator state.
   logic [RATE_BITS-1:0]  implied_star = LOW_RATING;
   logic [SUM_BITS-1:0]   squared_sum = '0;
   logic [COUNT_BITS-1:0] scored_tally = '0;

   separator_stream_rmse_core dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_rating_word (req_rating_word),
      .req_prediction  (req_prediction),
      .req_last_item   (req_last_item),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_rmse_scaled (rsp_rmse_scaled),
      .rsp_rated_count (rsp_rated_count),
      .rsp_no_ratings  (rsp_no_ratings)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic logic [ROOT_BITS-1:0] floor_root(logic [SUM_BITS-1:0] value);
      logic [ROOT_BITS-1:0] root;
      logic [ROOT_BITS-1:0] trial;
      root = '0;
      for (int b = ROOT_BITS - 1; b >= 0; b--) begin
         trial = root | (ROOT_BITS'(1) << b);
         if (SUM_BITS'(trial) * SUM_BITS'(trial) <= value) root = trial;
      end
      return root;
   endfunction

   // Applies one accepted request and records the score a last request produces.
   function automatic void score_request(request_type req);
      longint diff;
      score_type outcome;
      if (req.rating_word == '0) begin
         implied_star = (implied_star >= TOP_RATING) ? LOW_RATING : implied_star + 1'b1;
      end else if (scored_tally != COUNT_LIMIT) begin
         diff = longint'(implied_star) * longint'(STAR_SCALE) - longint'(req.prediction);
         squared_sum += SUM_BITS'(diff * diff);
         scored_tally++;
      end
      if (req.last_item) begin
         if (scored_tally == '0) begin
            outcome.rmse_scaled = '0;
            outcome.rated_count = '0;
            outcome.no_ratings  = 1'b1;
         end else begin
            outcome.rmse_scaled = floor_root(squared_sum / scored_tally);
            outcome.rated_count = RATED_BITS'(scored_tally);
            outcome.no_ratings  = 1'b0;
         end
         expected_scores.push_back(outcome);
         implied_star = LOW_RATING;
         squared_sum  = '0;
         scored_tally = '0;
      end
   endfunction

   function automatic idle_mode_type current_mode();
      return idle_mode_type'((accepted_requests / PHASE_REQUESTS) % 4);
   endfunction

   function automatic logic sender_idles();
      case (current_mode())
         IDLE_SENDER: return $urandom_range(99) < 85;
         IDLE_BOTH:   return $urandom_range(99) < 33;
         default:     return 1'b0;
      endcase
   endfunction

   function automatic logic receiver_stalls();
      case (current_mode())
         IDLE_RECEIVER: return $urandom_range(99) < 85;
         IDLE_BOTH:     return $urandom_range(99) < 33;
         default:       return 1'b0;
      endcase
   endfunction

   function automatic void queue_request(logic [WORD_BITS-1:0] word,
                                         logic [PRED_BITS-1:0] pred, logic last);
      request_type req;
      req.rating_word = word;
      req.prediction  = pred;
      req.last_item   = last;
      pending_requests.push_back(req);
   endfunction

   function automatic logic [PRED_BITS-1:0] random_prediction();
      case ($urandom_range(7))
         0:       return '0;
         1:       return '1;
         2:       return PRED_BITS'($urandom_range(5) * 10000);
         default: return PRED_BITS'($urandom_range(65535));
      endcase
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            score_request('{req_rating_word, req_prediction, req_last_item});
            accepted_requests++;
         end
         if (!req_valid || req_ready) begin
            if (pending_requests.size() != 0 && !sender_idles()) begin
               next_request = pending_requests.pop_front();
               req_valid       <= 1'b1;
               req_rating_word <= next_request.rating_word;
               req_prediction  <= next_request.prediction;
               req_last_item   <= next_request.last_item;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_scores.size() == 0) begin
               $error("unexpected result: rmse_scaled %0d rated_count %0d no_ratings %0d",
                      rsp_rmse_scaled, rsp_rated_count, rsp_no_ratings);
               error_count++;
            end else begin
               observed_score = expected_scores.pop_front();
               if (rsp_rmse_scaled !== observed_score.rmse_scaled) begin
                  $error("rmse_scaled: expected %0d, got %0d",
                         observed_score.rmse_scaled, rsp_rmse_scaled);
                  error_count++;
               end
               if (rsp_rated_count !== observed_score.rated_count) begin
                  $error("rated_count: expected %0d, got %0d",
                         observed_score.rated_count, rsp_rated_count);
                  error_count++;
               end
               if (rsp_no_ratings !== observed_score.no_ratings) begin
                  $error("no_ratings: expected %0d, got %0d",
                         observed_score.no_ratings, rsp_no_ratings);
                  error_count++;
               end
            end
         end
         rsp_ready <= !receiver_stalls();
      end
   end

   initial begin
      int group_len;
      int group_kind;
      int guard;
      logic [WORD_BITS-1:0] word;

      // A lone separator marked last gives an empty mean.
      queue_request('0, 16'd1234, 1'b1);
      // Largest and smallest predictions at rating one.
      queue_request('1, '0, 1'b1);
      queue_request(32'h0000_0001, '1, 1'b1);
      // Walk the rating up to five, wrap it, and end on a separator.
      repeat (4) queue_request('0, '1, 1'b0);
      queue_request(32'h8000_0000, 16'd50000, 1'b0);
      queue_request('0, '0, 1'b0);
      queue_request(32'h5555_5555, '0, 1'b0);
      queue_request('0, '0, 1'b0);
      queue_request(32'hAAAA_AAAA, '1, 1'b0);
      queue_request('0, '0, 1'b1);
      // Exact predictions give a zero error.
      queue_request(32'h0001_0000, 16'd10000, 1'b0);
      queue_request(32'h0000_8000, 16'd10000, 1'b1);
      // One wrap of the rating before a single scored word marked last.
      repeat (6) queue_request('0, 16'd777, 1'b0);
      queue_request(32'hFFFF_0000, 16'd12345, 1'b1);

      while (pending_requests.size() < RANDOM_REQUESTS) begin
         group_kind = $urandom_range(9);
         group_len = (group_kind == 0) ? $urandom_range(30, 80) : $urandom_range(1, 16);
         for (int i = 0; i < group_len; i++) begin
            word = ($urandom_range(3) == 0) ? '0 : WORD_BITS'($urandom());
            // Some groups hold separators only and must report no ratings.
            if (group_kind == 1) word = '0;
            queue_request(word, random_prediction(), i == group_len - 1);
         end
      end

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      while (pending_requests.size() != 0 || req_valid) @(posedge clock);
      guard = 0;
      while (expected_scores.size() != 0 && guard < DRAIN_GUARD) begin
         @(posedge clock);
         guard++;
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_scores.size() != 0) begin
         $error("%0d expected results never arrived", expected_scores.size());
         error_count++;
      end

      if (error_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("FAILURE");
      $finish;
   end

endmodule
